FILE: hdl/phpm_pkg.sv
// Shared types, codes and instruction masks for the prologue hook pattern matcher.
`default_nettype none
package phpm_pkg;

    localparam int WINDOW_WORDS        = 5;
    localparam int MOV_CHAIN_LOOKAHEAD = 4;

    typedef logic [31:0]                   word_t;
    typedef logic [WINDOW_WORDS-1:0][31:0] window_t;
    typedef logic [1:0]                    isa_mode_t;
    typedef logic [3:0]                    pattern_t;

    // Instruction set selection codes.
    localparam isa_mode_t ISA_ARM32 = 2'd0;
    localparam isa_mode_t ISA_A64   = 2'd1;
    localparam isa_mode_t ISA_X86   = 2'd2;

    // Pattern codes reported with each result item.
    localparam pattern_t PAT_NONE      = 4'd0;
    localparam pattern_t PAT_ARM_LDR   = 4'd1;
    localparam pattern_t PAT_ARM_B     = 4'd2;
    localparam pattern_t PAT_THUMB_LDR = 4'd3;
    localparam pattern_t PAT_THUMB_B4  = 4'd4;
    localparam pattern_t PAT_THUMB_B2  = 4'd5;
    localparam pattern_t PAT_BX_LDR    = 4'd6;
    localparam pattern_t PAT_A64_B     = 4'd7;
    localparam pattern_t PAT_LDR_BR    = 4'd8;
    localparam pattern_t PAT_ADRP_BR   = 4'd9;
    localparam pattern_t PAT_MOV_BR    = 4'd10;
    localparam pattern_t PAT_X86_JMP   = 4'd11;

    // AArch32 masks.
    localparam word_t LDR_PC_A1_MASK = 32'hfe5f_f000;
    localparam word_t LDR_PC_A1_VAL  = 32'he41f_f000;
    localparam word_t LDR_PC_T2_MASK = 32'hf000_ff7f;
    localparam word_t LDR_PC_T2_VAL  = 32'hf000_f85f;
    localparam word_t B_T4_MASK      = 32'hd000_f800;
    localparam word_t B_T4_VAL       = 32'h9000_f000;

    // AArch64 masks.
    localparam word_t A64_B_MASK     = 32'hfc00_0000;
    localparam word_t A64_B_VAL      = 32'h1400_0000;
    localparam word_t A64_BR_MASK    = 32'hffff_fc0f;
    localparam word_t A64_BR_VAL     = 32'hd61f_0000;
    localparam word_t A64_MOV_MASK   = 32'h9f80_0000;
    localparam word_t A64_MOV_VAL    = 32'h9280_0000;
    localparam word_t A64_LDR_MASK   = 32'hff00_0000;
    localparam word_t A64_LDR_VAL    = 32'h5800_0000;
    localparam word_t A64_ADRP_MASK  = 32'h9f00_0000;
    localparam word_t A64_ADRP_VAL   = 32'h9000_0000;

endpackage
`default_nettype wire

FILE: hdl/phpm_ifs.sv
// Valid/ready channel interfaces for prologue items and match results.
`default_nettype none
interface phpm_in_if;
    logic        valid;
    logic        ready;
    logic        null_symbol;
    logic        thumb_bit;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;

    modport source (output valid, null_symbol, thumb_bit, word0, word1, word2, word3, word4,
                    input ready);
    modport sink (input valid, null_symbol, thumb_bit, word0, word1, word2, word3, word4,
                  output ready);
endinterface

interface phpm_out_if;
    logic       valid;
    logic       ready;
    logic       hooked;
    logic [3:0] pattern;

    modport source (output valid, hooked, pattern, input ready);
    modport sink (input valid, hooked, pattern, output ready);
endinterface
`default_nettype wire

FILE: hdl/phpm_arm32_chk.sv
// AArch32 prologue checker covering ARM and Thumb hook patterns.
`default_nettype none
module phpm_arm32_chk (
    input  wire logic             thumb,
    input  wire phpm_pkg::word_t  w0,
    input  wire phpm_pkg::word_t  w1,
    input  wire phpm_pkg::word_t  w2,
    output phpm_pkg::pattern_t    pattern
);
    import phpm_pkg::*;

    function automatic logic ldr_pc_arm(input word_t x);
        return (x & LDR_PC_A1_MASK) == LDR_PC_A1_VAL;
    endfunction

    function automatic logic ldr_pc_thumb(input word_t x);
        return (x & LDR_PC_T2_MASK) == LDR_PC_T2_VAL;
    endfunction

    logic [15:0] h0;
    logic [15:0] hs;
    logic        skip;
    word_t       v;
    word_t       nxt;

    assign h0   = w0[15:0];
    // A 16-bit NOP-class hint or a MOV of a register onto itself shifts the window by one halfword.
    assign skip = ((h0 & 16'hff0f) == 16'hbf00) ||
                  ((h0[15:8] == 8'h46) && (h0[6:3] == {h0[7], h0[2:0]}));
    assign v    = skip ? {w1[15:0], w0[31:16]} : w0;
    assign nxt  = skip ? {w2[15:0], w1[31:16]} : w1;
    assign hs   = v[15:0];

    always_comb
    begin
        pattern = PAT_NONE;
        if (!thumb)
        begin
            priority if (ldr_pc_arm(w0))                 pattern = PAT_ARM_LDR;
            else if (w0[31:24] == 8'hea)                  pattern = PAT_ARM_B;
            else                                          pattern = PAT_NONE;
        end
        else
        begin
            priority if (ldr_pc_thumb(w0))                pattern = PAT_THUMB_LDR;
            else if ((w0 & B_T4_MASK) == B_T4_VAL)        pattern = PAT_THUMB_B4;
            else if (h0[15:11] == 5'b11100)               pattern = PAT_THUMB_B2;
            else if (ldr_pc_thumb(v))                     pattern = PAT_THUMB_LDR;
            else if (hs == 16'h4778 && ldr_pc_arm(nxt))   pattern = PAT_BX_LDR;
            else                                          pattern = PAT_NONE;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/phpm_a64_chk.sv
// AArch64 prologue checker: direct branch, literal or page load then BR, MOV chain then BR.
`default_nettype none
module phpm_a64_chk (
    input  wire phpm_pkg::window_t w,
    output phpm_pkg::pattern_t     pattern
);
    import phpm_pkg::*;

    function automatic logic is_br(input word_t x);
        return (x & A64_BR_MASK) == A64_BR_VAL;
    endfunction

    function automatic logic is_mov(input word_t x);
        return (x & A64_MOV_MASK) == A64_MOV_VAL;
    endfunction

    logic       br1_same;
    logic       chain_hit;
    logic       chain_stop;
    logic [4:0] reg0;

    assign reg0     = w[0][4:0];
    assign br1_same = is_br(w[1]) && (w[1][9:5] == reg0);

    // The MOV chain walks the following words; a BR on another register or a
    // MOV to another register ends the walk, anything else is stepped over.
    always_comb
    begin
        chain_hit  = 1'b0;
        chain_stop = 1'b0;
        for (int i = 1; i <= MOV_CHAIN_LOOKAHEAD; i++)
        begin
            if (!chain_hit && !chain_stop)
            begin
                if (is_br(w[3'(i)]))
                begin
                    if (w[3'(i)][9:5] == reg0)
                        chain_hit = 1'b1;
                    else
                        chain_stop = 1'b1;
                end
                else if (is_mov(w[3'(i)]) && (w[3'(i)][4:0] != reg0))
                begin
                    chain_stop = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        priority if ((w[0] & A64_B_MASK) == A64_B_VAL)                pattern = PAT_A64_B;
        else if ((w[0] & A64_LDR_MASK) == A64_LDR_VAL && br1_same)    pattern = PAT_LDR_BR;
        else if ((w[0] & A64_ADRP_MASK) == A64_ADRP_VAL && br1_same)  pattern = PAT_ADRP_BR;
        else if (is_mov(w[0]) && chain_hit)                           pattern = PAT_MOV_BR;
        else                                                          pattern = PAT_NONE;
    end
endmodule
`default_nettype wire

FILE: hdl/phpm_x86_chk.sv
// x86 prologue checker: the first byte is a jump opcode.
`default_nettype none
module phpm_x86_chk (
    input  wire logic [7:0]    opcode,
    output phpm_pkg::pattern_t pattern
);
    import phpm_pkg::*;

    logic is_jump;

    assign is_jump = (opcode == 8'he9) || (opcode == 8'hea) || (opcode == 8'heb) ||
                     (opcode == 8'h84) || (opcode == 8'h74) || (opcode == 8'he3) ||
                     (opcode >= 8'h71 && opcode <= 8'h7f) ||
                     (opcode >= 8'h81 && opcode <= 8'h8f);

    assign pattern = is_jump ? PAT_X86_JMP : PAT_NONE;
endmodule
`default_nettype wire

FILE: hdl/prologue_hook_pattern_matcher.sv
// Top level of the prologue hook pattern matcher: input stage, checkers and result stage.
//
// The probe channel carries one item per function entry: a null flag, the
// address low bit that selects Thumb decoding, and five little-endian words
// read at the entry. The verdict channel returns one item for each probe
// item: hooked, and the code of the first pattern that matched. The user
// must write isa_mode, which picks the instruction set, via cfg_wr_en and
// cfg_wr_data only while no item is in flight (unenforced). Mode 3 never matches.
//
// An accepted item lands in the input register; the checkers for all three
// instruction sets work on it in mask-and-compare logic, and the verdict is
// captured in the result register. A new item can be accepted every cycle
// while the receiver keeps taking verdicts.
//
// When the receiver stalls, the result register holds its verdict and the
// input register keeps one more item; probe.ready drops only when both are
// full. Reset empties both stages and returns isa_mode to AArch32.
`default_nettype none
module prologue_hook_pattern_matcher (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    phpm_in_if.sink         probe,
    phpm_out_if.source      verdict
);
    import phpm_pkg::*;

    isa_mode_t isa_mode_reg;

    // Input stage.
    logic      s1_valid_reg;
    logic      s1_null_reg;
    logic      s1_thumb_reg;
    window_t   s1_window_reg;
    logic      s1_advance;

    // Result stage.
    logic      s2_valid_reg;
    logic      s2_hooked_reg;
    pattern_t  s2_pattern_reg;

    pattern_t  arm32_pattern;
    pattern_t  a64_pattern;
    pattern_t  x86_pattern;
    pattern_t  pattern_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            isa_mode_reg <= ISA_ARM32;
        else if (cfg_wr_en)
            isa_mode_reg <= cfg_wr_data;
    end

    // The input stage moves on whenever the result register is empty or is
    // being drained this cycle.
    assign s1_advance  = !s2_valid_reg || verdict.ready;
    assign probe.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (probe.ready)
            s1_valid_reg <= probe.valid;
    end

    always_ff @(posedge clk)
    begin
        if (probe.ready && probe.valid)
        begin
            s1_null_reg   <= probe.null_symbol;
            s1_thumb_reg  <= probe.thumb_bit;
            s1_window_reg <= {probe.word4, probe.word3, probe.word2, probe.word1, probe.word0};
        end
    end

    phpm_arm32_chk u_arm32 (
        .thumb   (s1_thumb_reg),
        .w0      (s1_window_reg[0]),
        .w1      (s1_window_reg[1]),
        .w2      (s1_window_reg[2]),
        .pattern (arm32_pattern)
    );

    phpm_a64_chk u_a64 (
        .w       (s1_window_reg),
        .pattern (a64_pattern)
    );

    phpm_x86_chk u_x86 (
        .opcode  (s1_window_reg[0][7:0]),
        .pattern (x86_pattern)
    );

    // A null function pointer is never reported as hooked.
    always_comb
    begin
        pattern_next = PAT_NONE;
        if (!s1_null_reg)
        begin
            unique case (isa_mode_reg)
                ISA_ARM32: pattern_next = arm32_pattern;
                ISA_A64:   pattern_next = a64_pattern;
                ISA_X86:   pattern_next = x86_pattern;
                default:   pattern_next = PAT_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            s2_pattern_reg <= pattern_next;
            s2_hooked_reg  <= (pattern_next != PAT_NONE);
        end
    end

    assign verdict.valid   = s2_valid_reg;
    assign verdict.hooked  = s2_hooked_reg;
    assign verdict.pattern = s2_pattern_reg;
endmodule
`default_nettype wire

FILE: verif/tb_prologue_hook_pattern_matcher.sv
// Self-checking testbench for the prologue hook pattern matcher, with its own pattern predictor.
`timescale 1ns / 1ps

module tb_prologue_hook_pattern_matcher;
    import phpm_pkg::*;

    // The fourth mode code has no decoder behind it and must never report a hook.
    localparam isa_mode_t ISA_UNUSED = 2'd3;

    // Encodings that the package does not name: the ARM B immediate, the Thumb
    // 16-bit B, the Thumb NOP-like hint, MOV Rd,Rd, and BX PC.
    localparam word_t       ARM_B_MASK      = 32'hff00_0000;
    localparam word_t       ARM_B_VAL       = 32'hea00_0000;
    localparam logic [15:0] T1_B_MASK       = 16'hf800;
    localparam logic [15:0] T1_B_VAL        = 16'he000;
    localparam logic [15:0] T1_NOP_MASK     = 16'hff0f;
    localparam logic [15:0] T1_NOP_VAL      = 16'hbf00;
    localparam logic [7:0]  T1_MOV_OPC      = 8'h46;
    localparam logic [15:0] BX_PC_T1        = 16'h4778;
    localparam word_t       A64_RD_MASK     = 32'h0000_001f;
    localparam word_t       A64_BR_REG_MASK = 32'h0000_03e0;

    localparam int RANDOM_PER_PHASE = 58;
    localparam int NUM_PHASES       = 7;
    // No item or result moves for this many cycles means the block is stuck.
    // The longest legal quiet stretch is the deliberate receiver hold;
    // everything else is shorter.
    localparam int WATCHDOG_LIMIT   = 1500;

    typedef struct packed {
        logic    null_symbol;
        logic    thumb_bit;
        window_t words;
    } probe_t;

    // Predicts the pattern code for every accepted probe item, keeps the
    // predictions in arrival order, and compares each verdict item with the
    // oldest one.
    class hook_verdict_checker;
        isa_mode_t mode;
        pattern_t  expected_patterns[$];
        int        errors;

        function new();
            mode   = ISA_ARM32;
            errors = 0;
        endfunction

        function bit fits(word_t x, word_t mask, word_t val);
            return (x & mask) == val;
        endfunction

        function bit is_br(word_t x);
            return fits(x, A64_BR_MASK, A64_BR_VAL);
        endfunction

        function bit is_mov(word_t x);
            return fits(x, A64_MOV_MASK, A64_MOV_VAL);
        endfunction

        // A 16-bit hint or a MOV of a register onto itself shifts the Thumb
        // window by one halfword.
        function bit is_t1_skip(logic [15:0] h);
            return ((h & T1_NOP_MASK) == T1_NOP_VAL) ||
                   (h[15:8] == T1_MOV_OPC && h[6:3] == {h[7], h[2:0]});
        endfunction

        function pattern_t arm_pattern(word_t w0);
            if (fits(w0, LDR_PC_A1_MASK, LDR_PC_A1_VAL)) return PAT_ARM_LDR;
            if (fits(w0, ARM_B_MASK, ARM_B_VAL)) return PAT_ARM_B;
            return PAT_NONE;
        endfunction

        function pattern_t thumb_pattern(window_t w);
            word_t       body;
            word_t       tail;
            logic [15:0] half;
            if (fits(w[0], LDR_PC_T2_MASK, LDR_PC_T2_VAL)) return PAT_THUMB_LDR;
            if (fits(w[0], B_T4_MASK, B_T4_VAL)) return PAT_THUMB_B4;
            half = w[0][15:0];
            if ((half & T1_B_MASK) == T1_B_VAL) return PAT_THUMB_B2;
            body = w[0];
            tail = w[1];
            if (is_t1_skip(half))
            begin
                body = {w[1][15:0], w[0][31:16]};
                tail = {w[2][15:0], w[1][31:16]};
                half = body[15:0];
            end
            if (fits(body, LDR_PC_T2_MASK, LDR_PC_T2_VAL)) return PAT_THUMB_LDR;
            if (half == BX_PC_T1 && fits(tail, LDR_PC_A1_MASK, LDR_PC_A1_VAL))
                return PAT_BX_LDR;
            return PAT_NONE;
        endfunction

        function pattern_t a64_pattern(window_t w);
            logic [4:0] rd;
            int         i;
            if (fits(w[0], A64_B_MASK, A64_B_VAL)) return PAT_A64_B;
            if (fits(w[0], A64_LDR_MASK, A64_LDR_VAL) && is_br(w[1]) &&
                w[0][4:0] == w[1][9:5]) return PAT_LDR_BR;
            if (fits(w[0], A64_ADRP_MASK, A64_ADRP_VAL) && is_br(w[1]) &&
                w[0][4:0] == w[1][9:5]) return PAT_ADRP_BR;
            if (is_mov(w[0]))
            begin
                rd = w[0][4:0];
                // Words that are neither BR nor MOV are stepped over; a BR or
                // MOV on any other register ends the chain.
                for (i = 1; i <= MOV_CHAIN_LOOKAHEAD && i < WINDOW_WORDS; i++)
                begin
                    if (is_br(w[i]))
                    begin
                        if (w[i][9:5] != rd) break;
                        return PAT_MOV_BR;
                    end
                    else if (is_mov(w[i]))
                    begin
                        if (w[i][4:0] != rd) break;
                    end
                end
            end
            return PAT_NONE;
        endfunction

        function pattern_t x86_pattern(word_t w0);
            logic [7:0] op;
            op = w0[7:0];
            if (op inside {8'he9, 8'hea, 8'heb, 8'h84, 8'h74, 8'he3,
                           [8'h71:8'h7f], [8'h81:8'h8f]}) return PAT_X86_JMP;
            return PAT_NONE;
        endfunction

        function pattern_t predict_pattern(probe_t p);
            if (p.null_symbol) return PAT_NONE;
            case (mode)
                ISA_ARM32: return p.thumb_bit ? thumb_pattern(p.words) : arm_pattern(p.words[0]);
                ISA_A64:   return a64_pattern(p.words);
                ISA_X86:   return x86_pattern(p.words[0]);
                default:   return PAT_NONE;
            endcase
        endfunction

        function void note_probe(probe_t p);
            expected_patterns.push_back(predict_pattern(p));
        endfunction

        function int pending();
            return expected_patterns.size();
        endfunction

        task report(string what, int want, int got);
            $display("ERROR at %0t ns: %s: expected %0d, got %0d", $time, what, want, got);
            errors++;
        endtask

        task check_verdict(logic hooked, pattern_t pattern);
            pattern_t want;
            if (expected_patterns.size() == 0)
            begin
                report("verdict item with no probe item outstanding", -1, int'(pattern));
                return;
            end
            want = expected_patterns.pop_front();
            if (hooked !== (want != PAT_NONE))
                report("hooked", int'(want != PAT_NONE), int'(hooked));
            if (pattern !== want) report("pattern", int'(want), int'(pattern));
        endtask
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [1:0]      cfg_wr_data;
    phpm_in_if       probe_ch ();
    phpm_out_if      verdict_ch ();

    hook_verdict_checker sb = new();

    // Both sides insert random gaps while this is set; one phase runs flat out.
    bit idle_on;
    // Cycles for which the receiver must keep ready low, set once by the
    // stimulus to let the pipeline fill up and push back on the sender.
    int hold_left = 0;
    int quiet_cycles = 0;

    prologue_hook_pattern_matcher uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .probe       (probe_ch),
        .verdict     (verdict_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic word_t plant(word_t base, word_t mask, word_t val);
        return (base & ~mask) | val;
    endfunction

    function automatic word_t br_word(logic [4:0] rn);
        return plant($urandom, A64_BR_MASK | A64_BR_REG_MASK, A64_BR_VAL | (word_t'(rn) << 5));
    endfunction

    function automatic word_t mov_word(logic [4:0] rd);
        return plant($urandom, A64_MOV_MASK | A64_RD_MASK, A64_MOV_VAL | word_t'(rd));
    endfunction

    function automatic probe_t mk(logic nul, logic thumb, word_t w0, word_t w1 = '0,
                                  word_t w2 = '0, word_t w3 = '0, word_t w4 = '0);
        probe_t p;
        p.null_symbol = nul;
        p.thumb_bit   = thumb;
        p.words       = {w4, w3, w2, w1, w0};
        return p;
    endfunction

    // Plants one of the AArch32 hook shapes, or none, over random content. The Thumb
    // shapes mostly get the Thumb bit so that they reach the Thumb decoder.
    function automatic void shape_arm32(inout probe_t p);
        word_t       body;
        logic [15:0] skip;
        logic [3:0]  rd;
        int          kind;
        rd   = 4'($urandom_range(0, 15));
        skip = $urandom_range(0, 1) ? {T1_NOP_VAL[15:8], 4'($urandom_range(0, 15)), 4'h0}
                                    : {T1_MOV_OPC, rd[3], rd, rd[2:0]};
        kind = $urandom_range(0, 9);
        case (kind)
            0: p.words[0] = plant(p.words[0], LDR_PC_A1_MASK, LDR_PC_A1_VAL);
            1: p.words[0] = plant(p.words[0], ARM_B_MASK, ARM_B_VAL);
            2: p.words[0] = plant(p.words[0], LDR_PC_T2_MASK, LDR_PC_T2_VAL);
            3: p.words[0] = plant(p.words[0], B_T4_MASK, B_T4_VAL);
            4: p.words[0][15:11] = T1_B_VAL[15:11];
            5:
            begin
                body = plant($urandom, LDR_PC_T2_MASK, LDR_PC_T2_VAL);
                p.words[0]        = {body[15:0], skip};
                p.words[1][15:0]  = body[31:16];
            end
            6:
            begin
                p.words[0][15:0] = BX_PC_T1;
                p.words[1]       = plant(p.words[1], LDR_PC_A1_MASK, LDR_PC_A1_VAL);
            end
            7:
            begin
                body = plant($urandom, LDR_PC_A1_MASK, LDR_PC_A1_VAL);
                p.words[0]        = {BX_PC_T1, skip};
                p.words[1][31:16] = body[15:0];
                p.words[2][15:0]  = body[31:16];
            end
            default: ;
        endcase
        if (kind >= 2 && kind <= 7) p.thumb_bit = ($urandom_range(0, 3) != 0);
    endfunction

    // AArch64 shapes: B, LDR or ADRP followed by BR, and MOV chains whose BR
    // lands anywhere in the lookahead, sometimes on the wrong register.
    function automatic void shape_a64(inout probe_t p);
        logic [4:0] rn;
        logic [4:0] other;
        int         pos;
        int         i;
        rn    = 5'($urandom_range(0, 31));
        other = rn ^ 5'($urandom_range(1, 31));
        case ($urandom_range(0, 9))
            0: p.words[0] = plant(p.words[0], A64_B_MASK, A64_B_VAL);
            1:
            begin
                p.words[0] = plant(p.words[0], A64_LDR_MASK | A64_RD_MASK,
                                   A64_LDR_VAL | word_t'(rn));
                p.words[1] = br_word($urandom_range(0, 3) == 0 ? other : rn);
            end
            2:
            begin
                p.words[0] = plant(p.words[0], A64_ADRP_MASK | A64_RD_MASK,
                                   A64_ADRP_VAL | word_t'(rn));
                p.words[1] = br_word($urandom_range(0, 3) == 0 ? other : rn);
            end
            3, 4, 5:
            begin
                p.words[0] = mov_word(rn);
                pos = $urandom_range(1, MOV_CHAIN_LOOKAHEAD);
                for (i = 1; i < pos; i++)
                    if ($urandom_range(0, 2) == 0) p.words[i] = mov_word(rn);
                if (pos > 1 && $urandom_range(0, 5) == 0) p.words[1] = mov_word(other);
                p.words[pos] = br_word($urandom_range(0, 4) == 0 ? other : rn);
            end
            default: ;
        endcase
    endfunction

    // x86: the jump opcodes and the bytes just around each range.
    function automatic void shape_x86(inout probe_t p);
        case ($urandom_range(0, 4))
            0: p.words[0][7:0] = 8'he9 + 8'($urandom_range(0, 2));
            1: p.words[0][7:0] = 8'($urandom_range(32'h70, 32'h80));
            2: p.words[0][7:0] = 8'($urandom_range(32'h80, 32'h90));
            3: p.words[0][7:0] = $urandom_range(0, 1) ? 8'h84 :
                                 ($urandom_range(0, 1) ? 8'h74 : 8'he3);
            default: ;
        endcase
    endfunction

    function automatic probe_t make_probe(isa_mode_t mode);
        probe_t    p;
        isa_mode_t flavor;
        int        k;
        p.null_symbol = ($urandom_range(0, 15) == 0);
        p.thumb_bit   = 1'($urandom_range(0, 1));
        for (k = 0; k < WINDOW_WORDS; k++) p.words[k] = $urandom;
        // With no decoder selected, any shape at all should still come out clean.
        flavor = (mode == ISA_UNUSED) ? isa_mode_t'($urandom_range(0, 2)) : mode;
        case (flavor)
            ISA_ARM32: shape_arm32(p);
            ISA_A64:   shape_a64(p);
            default:   shape_x86(p);
        endcase
        // Now and then break a shape by flipping one bit somewhere in the window.
        if ($urandom_range(0, 7) == 0)
        begin
            k = $urandom_range(0, WINDOW_WORDS - 1);
            p.words[k] = p.words[k] ^ (32'd1 << $urandom_range(0, 31));
        end
        return p;
    endfunction

    // Offers one probe item after an optional gap and returns at the edge where
    // it is taken. valid stays high between back-to-back items.
    task automatic send_probe(probe_t p);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            probe_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        probe_ch.valid       <= 1'b1;
        probe_ch.null_symbol <= p.null_symbol;
        probe_ch.thumb_bit   <= p.thumb_bit;
        probe_ch.word0       <= p.words[0];
        probe_ch.word1       <= p.words[1];
        probe_ch.word2       <= p.words[2];
        probe_ch.word3       <= p.words[3];
        probe_ch.word4       <= p.words[4];
        do @(posedge clk); while (probe_ch.ready !== 1'b1);
        sb.note_probe(p);
    endtask

    // Stops offering and waits until every verdict has come back, so that the
    // mode register may be rewritten.
    task automatic drain();
        probe_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic set_isa_mode(isa_mode_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.mode = m;
    endtask

    // Hand-picked windows: field extremes, each pattern in its plain form,
    // both Thumb skips, the BR mask quirk, and MOV chains that end early.
    task automatic run_directed(isa_mode_t mode);
        case (mode)
            ISA_ARM32:
            begin
                send_probe(mk(1'b0, 1'b0, '0, '0, '0, '0, '0));
                send_probe(mk(1'b1, 1'b1, '1, '1, '1, '1, '1));
                send_probe(mk(1'b0, 1'b0, '1, '1, '1, '1, '1));
                send_probe(mk(1'b0, 1'b0, 32'he51f_f004));
                send_probe(mk(1'b0, 1'b0, 32'hea00_0010));
                send_probe(mk(1'b0, 1'b1, 32'hea00_0010));
                send_probe(mk(1'b0, 1'b1, 32'hf000_f8df));
                send_probe(mk(1'b0, 1'b1, 32'h9000_f000));
                send_probe(mk(1'b0, 1'b1, 32'h0000_e7fe));
                // Hint first, then LDR.W PC straddling the first two words.
                send_probe(mk(1'b0, 1'b1, 32'hf8df_bf00, 32'h0000_f000));
                send_probe(mk(1'b0, 1'b1, 32'h0000_4778, 32'he51f_f004));
                // MOV SP,SP first, then BX PC and an ARM LDR PC one halfword late.
                send_probe(mk(1'b0, 1'b1, 32'h4778_46ed, 32'hf004_0000, 32'h0000_e51f));
            end
            ISA_A64:
            begin
                send_probe(mk(1'b0, 1'b0, '1, '1, '1, '1, '1));
                send_probe(mk(1'b0, 1'b0, 32'h1400_0001));
                send_probe(mk(1'b0, 1'b0, 32'h5800_0050, 32'hd61f_0200));
                send_probe(mk(1'b0, 1'b1, 32'h9000_0011, 32'hd61f_0220));
                // Bit 4 of the BR word is outside the compare, bit 0 is inside.
                send_probe(mk(1'b0, 1'b0, 32'h5800_0050, 32'hd61f_0210));
                send_probe(mk(1'b0, 1'b0, 32'h5800_0050, 32'hd61f_0201));
                send_probe(mk(1'b0, 1'b0, 32'hd280_0010, 32'hf2a0_0010, 32'hd61f_0200));
                send_probe(mk(1'b0, 1'b0, 32'hd280_0010, 32'h1111_1111, 32'h2222_2222,
                              32'h3333_3333, 32'hd61f_0200));
                send_probe(mk(1'b0, 1'b0, 32'hd280_0010, 32'hd61f_0220, 32'hd61f_0200));
                send_probe(mk(1'b0, 1'b0, 32'hd280_0010, 32'hd280_0011, 32'hd61f_0200));
            end
            ISA_X86:
            begin
                send_probe(mk(1'b0, 1'b0, 32'h0000_00e9));
                send_probe(mk(1'b1, 1'b0, 32'h0000_00e9));
                send_probe(mk(1'b0, 1'b0, 32'h0000_0070));
                send_probe(mk(1'b0, 1'b1, 32'h0000_007f));
                send_probe(mk(1'b0, 1'b0, 32'h0000_0080));
                send_probe(mk(1'b0, 1'b0, 32'h0000_008f));
                send_probe(mk(1'b0, 1'b0, 32'h0000_0090));
            end
            default:
            begin
                send_probe(mk(1'b0, 1'b0, 32'hea00_00e9));
                send_probe(mk(1'b0, 1'b1, 32'h1400_0000));
            end
        endcase
    endtask

    // Receiver: checks each verdict item at the edge where it is taken, then
    // picks ready for the next cycle. A pending hold wins over random stalls.
    initial
    begin
        int stall_left;
        int n;
        stall_left = 0;
        verdict_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1)
                sb.check_verdict(verdict_ch.hooked, verdict_ch.pattern);
            if (hold_left > 0)
            begin
                verdict_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                verdict_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                n = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (n > 0)
                begin
                    verdict_ch.ready <= 1'b0;
                    stall_left = n - 1;
                end
                else
                begin
                    verdict_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Any handshake on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((probe_ch.valid === 1'b1 && probe_ch.ready === 1'b1) ||
            (verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus: each phase selects a mode while the block is empty, runs the
    // hand-picked windows the first time that mode comes up, then random
    // items. Phase 1 starts its random part under a long receiver hold; phase
    // 2 runs with no gaps on either side.
    initial
    begin
        isa_mode_t phase_modes [NUM_PHASES];
        int        phase;
        int        n;
        phase_modes = '{ISA_ARM32, ISA_A64, ISA_X86, ISA_UNUSED, ISA_A64, ISA_ARM32, ISA_X86};
        idle_on               = 1'b1;
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= ISA_ARM32;
        probe_ch.valid       <= 1'b0;
        probe_ch.null_symbol <= 1'b0;
        probe_ch.thumb_bit   <= 1'b0;
        probe_ch.word0       <= '0;
        probe_ch.word1       <= '0;
        probe_ch.word2       <= '0;
        probe_ch.word3       <= '0;
        probe_ch.word4       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle_on = (phase != 2);
            set_isa_mode(phase_modes[phase]);
            if (phase < 4) run_directed(phase_modes[phase]);
            if (phase == 1) hold_left = 150;
            for (n = 0; n < RANDOM_PER_PHASE; n++) send_probe(make_probe(phase_modes[phase]));
            drain();
        end

        // Keep the receiver running to catch any verdict item that should not exist.
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) sb.report("verdict items never delivered", 0, sb.pending());
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
